// ===== sv/dma4_pkg.sv =====
// ----------------------------------------------------------------------------
// dma4_pkg
// Shared types, codes and constants for the four-channel DMA controller.
// ----------------------------------------------------------------------------
package dma4_pkg;

    // Channel count and refresh divider
    localparam int NUM_CH         = 4;
    localparam int NUM_REQ        = 3;
    localparam int REFRESH_PERIOD = 16;
    localparam int REFRESH_W      = $clog2(REFRESH_PERIOD + 1);

    // Field widths
    localparam int FUNC_W = 3;
    localparam int PORT_W = 5;
    localparam int CH_W   = 2;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int ADDR_W = 24;
    localparam int OP_W   = 2;
    localparam int ERR_W  = 2;

    // Function codes
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_XFER    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REFRESH = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REQ     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_ACK     = 3'd5;

    // Register ports
    localparam logic [PORT_W-1:0] PORT_STATUS = 5'd8;
    localparam logic [PORT_W-1:0] PORT_MODE   = 5'd11;
    localparam logic [PORT_W-1:0] PORT_CLR_FF = 5'd12;
    localparam logic [PORT_W-1:0] PORT_MCLR   = 5'd13;

    // Memory operations
    localparam logic [OP_W-1:0] MEM_NONE  = 2'd0;
    localparam logic [OP_W-1:0] MEM_READ  = 2'd1;
    localparam logic [OP_W-1:0] MEM_WRITE = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_CASCADE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TYPE    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_CHAN    = 2'd3;

    // Transfer types (mode bits 3:2)
    localparam logic [1:0] XT_VERIFY  = 2'd0;
    localparam logic [1:0] XT_WRITE   = 2'd1;
    localparam logic [1:0] XT_READ    = 2'd2;
    localparam logic [1:0] XT_ILLEGAL = 2'd3;

    // Mode and command bits
    localparam int MODE_AUTOINIT = 4;
    localparam int MODE_DEC      = 5;
    localparam int CMD_DISABLE   = 2;
    localparam logic [1:0] MODE_CASCADE = 2'b11;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PORT_W-1:0] port;
        logic [CH_W-1:0]   channel;
        logic [BYTE_W-1:0] data;
        logic              level;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic [OP_W-1:0]   mem_op;
        logic [ADDR_W-1:0] mem_addr;
        logic [BYTE_W-1:0] mem_data;
        logic              ack;
        logic [ERR_W-1:0]  error_code;
    } t_result;

endpackage

// ===== sv/dma4_if.sv =====
// ----------------------------------------------------------------------------
// dma4_in_if / dma4_out_if
// Valid/ready channels for bus events in and results out.
// ----------------------------------------------------------------------------
interface dma4_in_if;
    import dma4_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [PORT_W-1:0] port;
    logic [CH_W-1:0]   channel;
    logic [BYTE_W-1:0] data;
    logic              level;

    modport source (output valid, func, port, channel, data, level, input ready);
    modport sink   (input valid, func, port, channel, data, level, output ready);
endinterface

interface dma4_out_if;
    import dma4_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic [OP_W-1:0]   mem_op;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_data;
    logic              ack;
    logic [ERR_W-1:0]  error_code;

    modport source (output valid, read_data, mem_op, mem_addr, mem_data, ack, error_code,
                    input ready);
    modport sink   (input valid, read_data, mem_op, mem_addr, mem_data, ack, error_code,
                    output ready);
endinterface

// ===== sv/dma4_core.sv =====
// ----------------------------------------------------------------------------
// dma4_core
// Channel register file and single-pass event decode; state commits on i_en.
// ----------------------------------------------------------------------------
module dma4_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  dma4_pkg::t_item   i_item,
    output dma4_pkg::t_result o_result
);
    import dma4_pkg::*;

    logic [WORD_W-1:0]    r_base_addr [NUM_CH];
    logic [WORD_W-1:0]    r_cur_addr  [NUM_CH];
    logic [WORD_W-1:0]    r_base_cnt  [NUM_CH];
    logic [WORD_W-1:0]    r_cur_cnt   [NUM_CH];
    logic [BYTE_W-1:0]    r_mode      [NUM_CH];
    logic [BYTE_W-1:0]    r_page      [NUM_CH];
    logic [NUM_CH-1:0]    r_chan_tc;
    logic [BYTE_W-1:0]    r_command;
    logic [NUM_CH-1:0]    r_status_tc;
    logic                 r_toggle;
    logic [NUM_REQ-1:0]   r_req;
    logic [REFRESH_W-1:0] r_refresh_div;

    logic [WORD_W-1:0]    n_base_addr [NUM_CH];
    logic [WORD_W-1:0]    n_cur_addr  [NUM_CH];
    logic [WORD_W-1:0]    n_base_cnt  [NUM_CH];
    logic [WORD_W-1:0]    n_cur_cnt   [NUM_CH];
    logic [BYTE_W-1:0]    n_mode      [NUM_CH];
    logic [BYTE_W-1:0]    n_page      [NUM_CH];
    logic [NUM_CH-1:0]    n_chan_tc;
    logic [BYTE_W-1:0]    n_command;
    logic [NUM_CH-1:0]    n_status_tc;
    logic                 n_toggle;
    logic [NUM_REQ-1:0]   n_req;
    logic [REFRESH_W-1:0] n_refresh_div;

    // Decode, update and step in one pass
    always_comb begin
        logic [CH_W-1:0]   pch;
        logic [CH_W-1:0]   ch;
        logic [CH_W-1:0]   mch;
        logic [CH_W-1:0]   sch;
        logic [WORD_W-1:0] rv;
        logic [WORD_W-1:0] wv;
        logic [1:0]        xtype;
        logic              do_step;
        logic [WORD_W-1:0] dec_cnt;

        pch     = i_item.port[2:1];
        ch      = i_item.channel;
        mch     = i_item.data[1:0];
        sch     = '0;
        rv      = '0;
        wv      = '0;
        xtype   = r_mode[ch][3:2];
        do_step = 1'b0;
        dec_cnt = '0;

        n_base_addr   = r_base_addr;
        n_cur_addr    = r_cur_addr;
        n_base_cnt    = r_base_cnt;
        n_cur_cnt     = r_cur_cnt;
        n_mode        = r_mode;
        n_page        = r_page;
        n_chan_tc     = r_chan_tc;
        n_command     = r_command;
        n_status_tc   = r_status_tc;
        n_toggle      = r_toggle;
        n_req         = r_req;
        n_refresh_div = r_refresh_div;
        o_result      = '0;

        case (i_item.func)
            FN_READ: begin
                if (i_item.port[4:3] == 2'b00) begin
                    rv = i_item.port[0] ? r_cur_cnt[pch] : r_cur_addr[pch];
                    o_result.read_data = r_toggle ? rv[15:8] : rv[7:0];
                    n_toggle = ~r_toggle;
                end else if (i_item.port == PORT_STATUS) begin
                    o_result.read_data = {{(BYTE_W-NUM_CH){1'b0}}, r_status_tc};
                    n_status_tc = '0;
                end
            end
            FN_WRITE: begin
                if (i_item.port[4:3] == 2'b00) begin
                    rv = i_item.port[0] ? r_cur_cnt[pch] : r_cur_addr[pch];
                    wv = r_toggle ? {i_item.data, rv[7:0]} : {rv[15:8], i_item.data};
                    n_toggle = ~r_toggle;
                    if (i_item.port[0]) begin
                        n_cur_cnt[pch] = wv;
                        if (r_toggle) begin
                            n_base_cnt[pch]  = wv;
                            n_chan_tc[pch]   = 1'b0;
                            n_status_tc[pch] = 1'b0;
                        end
                    end else begin
                        n_cur_addr[pch] = wv;
                        if (r_toggle) begin
                            n_base_addr[pch] = wv;
                        end
                    end
                end else if (i_item.port[4:2] == 3'b100) begin
                    n_page[i_item.port[1:0]] = i_item.data;
                end else begin
                    case (i_item.port)
                        PORT_STATUS: n_command = i_item.data;
                        PORT_MODE: begin
                            if (i_item.data[7:6] == MODE_CASCADE) begin
                                o_result.error_code = ERR_CASCADE;
                            end else begin
                                n_mode[mch]      = i_item.data;
                                n_chan_tc[mch]   = 1'b0;
                                n_status_tc[mch] = 1'b0;
                            end
                        end
                        PORT_CLR_FF, PORT_MCLR: n_toggle = 1'b0;
                        default: ;
                    endcase
                end
            end
            FN_XFER: begin
                o_result.mem_addr = {r_page[ch], r_cur_addr[ch]};
                if (!r_chan_tc[ch]) begin
                    case (xtype)
                        XT_ILLEGAL: o_result.error_code = ERR_TYPE;
                        XT_WRITE: begin
                            o_result.mem_op   = MEM_WRITE;
                            o_result.mem_data = i_item.data;
                            do_step           = 1'b1;
                        end
                        XT_READ: begin
                            o_result.mem_op = MEM_READ;
                            do_step         = 1'b1;
                        end
                        default: do_step = 1'b1;
                    endcase
                    sch = ch;
                end
            end
            FN_REFRESH: begin
                if (r_refresh_div >= REFRESH_W'(REFRESH_PERIOD - 1)) begin
                    n_refresh_div = '0;
                    do_step       = 1'b1;
                    sch           = '0;
                end else begin
                    n_refresh_div = r_refresh_div + 1'b1;
                end
            end
            FN_REQ: begin
                if (ch == CH_W'(NUM_REQ)) begin
                    o_result.error_code = ERR_CHAN;
                end else begin
                    n_req[ch] = i_item.level;
                end
            end
            FN_ACK: begin
                if (ch == CH_W'(NUM_REQ)) begin
                    o_result.error_code = ERR_CHAN;
                end else begin
                    o_result.ack = r_req[ch];
                    n_req[ch]    = 1'b0;
                end
            end
            default: ;
        endcase

        // Advance count and address; reload or flag terminal count on wrap
        if (do_step && !r_command[CMD_DISABLE]) begin
            dec_cnt         = r_cur_cnt[sch] - 1'b1;
            n_cur_cnt[sch]  = dec_cnt;
            n_cur_addr[sch] = r_mode[sch][MODE_DEC] ? r_cur_addr[sch] - 1'b1
                                                    : r_cur_addr[sch] + 1'b1;
            if (dec_cnt == '1) begin
                if (r_mode[sch][MODE_AUTOINIT]) begin
                    n_cur_cnt[sch]  = r_base_cnt[sch];
                    n_cur_addr[sch] = r_base_addr[sch];
                end else begin
                    n_chan_tc[sch]   = 1'b1;
                    n_status_tc[sch] = 1'b1;
                end
            end
        end
    end

    // Commit state for each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_base_addr[i] <= '0;
                r_cur_addr[i]  <= '0;
                r_base_cnt[i]  <= '0;
                r_cur_cnt[i]   <= '0;
                r_mode[i]      <= '0;
                r_page[i]      <= '0;
            end
            r_chan_tc     <= '0;
            r_command     <= '0;
            r_status_tc   <= '0;
            r_toggle      <= 1'b0;
            r_req         <= '0;
            r_refresh_div <= '0;
        end else if (i_en) begin
            r_base_addr   <= n_base_addr;
            r_cur_addr    <= n_cur_addr;
            r_base_cnt    <= n_base_cnt;
            r_cur_cnt     <= n_cur_cnt;
            r_mode        <= n_mode;
            r_page        <= n_page;
            r_chan_tc     <= n_chan_tc;
            r_command     <= n_command;
            r_status_tc   <= n_status_tc;
            r_toggle      <= n_toggle;
            r_req         <= n_req;
            r_refresh_div <= n_refresh_div;
        end
    end

endmodule

// ===== sv/dma_controller_four_channel.sv =====
// ----------------------------------------------------------------------------
// dma_controller_four_channel
// Four-channel DMA controller: register bus, transfers, refresh and requests.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one event per transfer: a register read or write, a DMA
//   transfer, a refresh tick, a request level change or an acknowledge.
//   o_out returns exactly one result per event: read byte, memory request
//   (operation, 24-bit address, data), acknowledge flag and error code.
//   An event is captured in an input register, then decoded and applied to
//   the channel registers as it moves on into an output register, from
//   which its result is offered; a stall can hold it in the input register.
//   Throughput is one event per cycle while the receiver keeps up, set by the
//   single pass through the channel register update between the two registers.
//   When the receiver stalls, the output register holds its result, the
//   input register keeps the next event, and i_in.ready drops only once both
//   are full; events are never lost or reordered.
//   Reset (i_rst_n low at a clock edge) clears every channel register, the
//   command and status bytes, the byte toggle, request flags, the refresh
//   divider and the valid flags of both pipeline registers.
// ----------------------------------------------------------------------------
module dma_controller_four_channel (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dma4_in_if.sink    i_in,
    dma4_out_if.source o_out
);
    import dma4_pkg::*;

    logic    r_s1_valid;
    t_item   r_s1_item;
    logic    r_out_valid;
    t_result r_out;
    logic    s1_adv;
    t_result core_result;

    // Move the held event on when the output register is free or draining
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_item.func    <= i_in.func;
            r_s1_item.port    <= i_in.port;
            r_s1_item.channel <= i_in.channel;
            r_s1_item.data    <= i_in.data;
            r_s1_item.level   <= i_in.level;
        end
    end

    dma4_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (s1_adv),
        .i_item   (r_s1_item),
        .o_result (core_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_data  = r_out.read_data;
    assign o_out.mem_op     = r_out.mem_op;
    assign o_out.mem_addr   = r_out.mem_addr;
    assign o_out.mem_data   = r_out.mem_data;
    assign o_out.ack        = r_out.ack;
    assign o_out.error_code = r_out.error_code;

endmodule
